[rtl/core/cpu_pkg.sv]
`default_nettype none
package cpu_pkg;

  localparam int NUM_ENTRIES = 12;
  localparam int IDX_W = 4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // operations of the shared add/sub unit
  typedef enum logic [2:0] {
    UOP_MUL  = 3'b001,
    UOP_DIV  = 3'b010,
    UOP_SQRT = 3'b100
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
    logic keep;    // multiply accumulates onto the current accumulator
    logic neg;     // multiply subtracts the product
    logic long_y;  // multiplier operand is a wide cross term
  } ucmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic qneg;
  } ustat_t;

  typedef struct packed {
    logic valid;
    logic is_point;
    logic singular;
    logic saturated;
  } rflag_t;

  // matrix indexes of the four factors of adjugate entry k: p*q - r*s
  function automatic logic [IDX_W-1:0] adj_addr(input logic [3:0] k, input logic [1:0] slot);
    logic [15:0] row;
    begin
      unique case (k)
        4'd0:    row = 16'h96A5;
        4'd1:    row = 16'hA192;
        4'd2:    row = 16'h5261;
        4'd3:    row = 16'hA486;
        4'd4:    row = 16'h82A0;
        4'd5:    row = 16'h6042;
        4'd6:    row = 16'h8594;
        4'd7:    row = 16'h9081;
        4'd8:    row = 16'h4150;
        default: row = 16'h0000;
      endcase
      return row[{slot, 2'b00} +: 4];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/cpu_unit.sv]
`default_nettype none
module cpu_unit import cpu_pkg::*; #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ucmd_t                  cmd,
  input  logic [4*VW+FB+4-1:0]   a_in,
  input  logic [4*VW+FB+4-1:0]   x_in,
  input  logic [4*VW+FB+4-1:0]   y_in,
  output ustat_t                 stat,
  output logic [4*VW+FB+4-1:0]   acc,
  output logic [4*VW+FB+4-1:0]   xs,
  output logic [4*VW+FB+4-1:0]   ys
);

  localparam int W  = 4*VW+FB+4;
  localparam int CW = $clog2(2*VW+2);
  localparam logic [W-1:0] SQ_BIT = {{(W-1){1'b0}}, 1'b1} << (4*VW-2);

  logic          busy;
  logic          done;
  logic          qneg;
  uop_t          op_r;
  logic          neg_r;
  logic [1:0]    pre;
  logic [CW-1:0] cnt;
  logic          last;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic          sub;
  logic [W-1:0]  sum;
  logic          ge;

  assign last = (cnt == CW'(1));

  // the one adder shared by multiply, divide and root
  always_comb begin
    opa = acc;
    opb = xs;
    sub = 1'b1;
    unique case (op_r)
      UOP_MUL: sub = neg_r ^ last;
      UOP_DIV: begin
        if (pre == 2'd2) begin
          opa = '0;
          opb = acc;
        end else if (pre == 2'd1) begin
          opa = '0;
          opb = xs;
        end
      end
      UOP_SQRT: opb = xs | ys;
      default: sub = 1'b1;
    endcase
    sum = opa + (sub ? ~opb : opb) + W'(sub);
    ge  = ~sum[W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        op_r  <= cmd.op;
        neg_r <= cmd.neg;
        pre   <= 2'd0;
        unique case (cmd.op)
          UOP_MUL: begin
            if (!cmd.keep) acc <= a_in;
            xs  <= x_in;
            ys  <= y_in;
            cnt <= cmd.long_y ? CW'(2*VW+1) : CW'(VW);
          end
          UOP_DIV: begin
            acc  <= a_in << FB;
            xs   <= x_in << (VW+1);
            ys   <= '0;
            qneg <= a_in[W-1] ^ x_in[W-1];
            pre  <= 2'd2;
            cnt  <= CW'(VW+2);
          end
          UOP_SQRT: begin
            acc <= a_in;
            xs  <= '0;
            ys  <= SQ_BIT;
            cnt <= CW'(2*VW);
          end
          default: busy <= 1'b0;
        endcase
      end else if (busy) begin
        unique case (op_r)
          UOP_MUL: begin
            if (ys[0]) acc <= sum;
            xs  <= xs << 1;
            ys  <= ys >> 1;
            cnt <= cnt - CW'(1);
            if (last) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          UOP_DIV: begin
            if (pre == 2'd2) begin
              if (acc[W-1]) acc <= sum;
              pre <= 2'd1;
            end else if (pre == 2'd1) begin
              if (xs[W-1]) xs <= sum;
              pre <= 2'd0;
            end else begin
              if (ge) acc <= sum;
              ys  <= {ys[W-2:0], ge};
              xs  <= xs >> 1;
              cnt <= cnt - CW'(1);
              if (last) begin
                busy <= 1'b0;
                done <= 1'b1;
              end
            end
          end
          UOP_SQRT: begin
            if (ge) begin
              acc <= sum;
              xs  <= (xs >> 1) | ys;
            end else begin
              xs <= xs >> 1;
            end
            ys  <= ys >> 2;
            cnt <= cnt - CW'(1);
            if (last) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.qneg = qneg;

endmodule
`default_nettype wire

[rtl/core/cpu_core.sv]
`default_nettype none
module cpu_core import cpu_pkg::*; #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_cmd,
  input  logic [3:0]    in_index,
  input  logic [VW-1:0] in_value,
  input  logic [VW-1:0] in_u,
  input  logic [VW-1:0] in_v,
  input  logic [VW-1:0] in_w,
  input  logic          out_free,
  output rflag_t        rf,
  output logic [VW-1:0] res_x,
  output logic [VW-1:0] res_y,
  output logic [VW-1:0] res_z
);

  localparam int W = 4*VW+FB+4;
  localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ADJ_A = 11'b00000000010,
    S_ADJ_B = 11'b00000000100,
    S_DET   = 11'b00000001000,
    S_NUM_C = 11'b00000010000,
    S_NUM_T = 11'b00000100000,
    S_SQ    = 11'b00001000000,
    S_CHECK = 11'b00010000000,
    S_ROOT  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_FETCH = 3'b001,
    PH_ISSUE = 3'b010,
    PH_WAIT  = 3'b100
  } phase_t;

  state_t state;
  phase_t phase;

  logic [VW-1:0] mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld;
  logic [IDX_W-1:0] raddr_a;
  logic [IDX_W-1:0] raddr_b;
  logic [VW-1:0] rda;
  logic [VW-1:0] rdb;
  logic [2:0] nz;

  logic [VW-1:0] cu, cv, cw;
  logic [W-1:0] radj;
  logic [W-1:0] rn [3];
  logic [W-1:0] rdet;
  logic [VW-1:0] ox [3];
  logic [1:0] i, j;
  logic ortho;
  logic sing;
  logic sat_acc;

  ucmd_t ucmd;
  ustat_t ustat;
  logic [W-1:0] ua, ux, uy;
  logic [W-1:0] uacc, uxs, uys;
  logic [3:0] k;
  logic [VW-1:0] coord;
  logic [VW+1:0] q;
  logic q_sat;
  logic [VW-1:0] q_val;
  logic load_hit;

  function automatic logic [W-1:0] sx(input logic [VW-1:0] v);
    return {{(W-VW){v[VW-1]}}, v};
  endfunction

  assign in_ready = (state == S_IDLE);
  assign load_hit = in_valid && in_ready && (in_cmd == CMD_LOAD) && (in_index < 4'(NUM_ENTRIES));
  assign k = 4'({i, 1'b0}) + 4'(i) + 4'(j);

  always_comb begin
    unique case (j)
      2'd0:    coord = cu;
      2'd1:    coord = cv;
      default: coord = cw;
    endcase
  end

  // matrix store, two registered read ports
  always_ff @(posedge clk) begin
    if (load_hit) mem[in_index] <= in_value;
    rda <= vld[raddr_a] ? mem[raddr_a] : '0;
    rdb <= vld[raddr_b] ? mem[raddr_b] : '0;
  end

  // operand routing per step
  always_comb begin
    raddr_a    = '0;
    raddr_b    = '0;
    ua         = '0;
    ux         = radj;
    uy         = sx(rda);
    ucmd.start = (phase == PH_ISSUE);
    ucmd.op    = UOP_MUL;
    ucmd.keep  = 1'b0;
    ucmd.neg   = 1'b0;
    ucmd.long_y = 1'b0;
    unique case (state)
      S_ADJ_A: begin
        raddr_a = adj_addr(k, 2'd0);
        raddr_b = adj_addr(k, 2'd1);
        ux = sx(rda);
        uy = sx(rdb);
      end
      S_ADJ_B: begin
        raddr_a = adj_addr(k, 2'd2);
        raddr_b = adj_addr(k, 2'd3);
        ux = sx(rda);
        uy = sx(rdb);
        ucmd.keep = 1'b1;
        ucmd.neg  = 1'b1;
      end
      S_DET: begin
        raddr_a = {2'b00, i};
        ua = (i == 2'd0) ? '0 : rdet;
      end
      S_NUM_C: begin
        uy = sx(coord);
        ua = (j == 2'd0) ? '0 : rn[i];
      end
      S_NUM_T: begin
        raddr_a = {j, 2'b11};
        ucmd.keep = 1'b1;
        ucmd.neg  = 1'b1;
      end
      S_SQ: begin
        ux = rn[i];
        uy = rn[i];
        ucmd.long_y = 1'b1;
        ucmd.keep = (i != 2'd0);
      end
      S_ROOT: begin
        ua = rdet;
        ucmd.op = UOP_SQRT;
      end
      S_DIV: begin
        ua = rn[i];
        ux = rdet;
        ucmd.op = UOP_DIV;
      end
      default: ucmd.start = 1'b0;
    endcase
  end

  cpu_unit #(.VW(VW), .FB(FB)) u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ucmd),
    .a_in (ua),
    .x_in (ux),
    .y_in (uy),
    .stat (ustat),
    .acc  (uacc),
    .xs   (uxs),
    .ys   (uys)
  );

  // quotient sign and clamp
  always_comb begin
    q = uys[VW+1:0];
    if (ustat.qneg) begin
      q_sat = (|q[VW+1:VW]) | (q[VW-1] & (|q[VW-2:0]));
      q_val = q_sat ? MINV : (~q[VW-1:0]) + VW'(1);
    end else begin
      q_sat = |q[VW+1:VW-1];
      q_val = q_sat ? MAXV : q[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FETCH;
      vld   <= '0;
      nz    <= '0;
    end else begin
      if (load_hit) begin
        vld[in_index] <= 1'b1;
        if (in_index == 4'd8)  nz[0] <= |in_value;
        if (in_index == 4'd9)  nz[1] <= |in_value;
        if (in_index == 4'd10) nz[2] <= |in_value;
      end
      unique case (phase)
        PH_FETCH: if (state != S_IDLE && state != S_CHECK && state != S_EMIT) phase <= PH_ISSUE;
        PH_ISSUE: phase <= PH_WAIT;
        default: ;
      endcase
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_cmd == CMD_SOLVE) begin
            cu <= in_u;
            cv <= in_v;
            cw <= in_w;
            ortho   <= ~|nz;
            i       <= 2'd0;
            j       <= (~|nz) ? 2'd2 : 2'd0;
            sing    <= 1'b0;
            sat_acc <= 1'b0;
            phase   <= PH_FETCH;
            state   <= S_ADJ_A;
          end
        end
        S_CHECK: begin
          if (rdet == '0) begin
            sing  <= 1'b1;
            state <= S_EMIT;
          end else begin
            i     <= 2'd0;
            state <= ortho ? S_ROOT : S_DIV;
          end
        end
        S_EMIT: if (out_free) state <= S_IDLE;
        default: begin
          if (phase == PH_WAIT && ustat.done) begin
            phase <= PH_FETCH;
            unique case (state)
              S_ADJ_A: state <= S_ADJ_B;
              S_ADJ_B: begin
                if (ortho) begin
                  rn[i] <= uacc;
                  if (i == 2'd2) begin
                    i <= 2'd0;
                    state <= S_SQ;
                  end else begin
                    i <= i + 2'd1;
                    state <= S_ADJ_A;
                  end
                end else begin
                  radj  <= uacc;
                  state <= (j == 2'd0) ? S_DET : S_NUM_C;
                end
              end
              S_DET: begin
                rdet  <= uacc;
                state <= S_NUM_C;
              end
              S_NUM_C: state <= S_NUM_T;
              S_NUM_T: begin
                rn[i] <= uacc;
                if (j == 2'd2) begin
                  j <= 2'd0;
                  if (i == 2'd2) state <= S_CHECK;
                  else begin
                    i <= i + 2'd1;
                    state <= S_ADJ_A;
                  end
                end else begin
                  j <= j + 2'd1;
                  state <= S_ADJ_A;
                end
              end
              S_SQ: begin
                if (i == 2'd2) begin
                  rdet  <= uacc;
                  state <= S_CHECK;
                end else begin
                  i <= i + 2'd1;
                end
              end
              S_ROOT: begin
                rdet  <= uxs;
                state <= S_DIV;
              end
              S_DIV: begin
                ox[i]   <= q_val;
                sat_acc <= sat_acc | q_sat;
                if (i == 2'd2) state <= S_EMIT;
                else i <= i + 2'd1;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign rf.valid     = (state == S_EMIT) && out_free;
  assign rf.is_point  = !ortho && !sing;
  assign rf.singular  = sing;
  assign rf.saturated = !sing && sat_acc;
  assign res_x = sing ? '0 : ox[0];
  assign res_y = sing ? '0 : ox[1];
  assign res_z = sing ? '0 : ox[2];

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ucmd.start |-> !ustat.busy)
    else $error("unit started while busy");

  a_load_stays: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_cmd == CMD_LOAD) |=> (state == S_IDLE))
    else $error("load left idle");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (rf.valid && rf.singular) |-> (res_x == '0 && res_y == '0 && res_z == '0
                                   && !rf.saturated && !rf.is_point))
    else $error("singular result not cleared");

endmodule
`default_nettype wire

[rtl/core/camera_point_unproject.sv]
// camera_point_unproject
// keeps a 3x4 projection matrix [A | t] in signed fixed point and back-projects
// image coordinates through it
// input stream (s_*): s_tuser is the command, 0 loads one matrix entry, 1 solves;
//   a load beat gives no result, an index above eleven is dropped
// a solve returns x = A^-1 (c - t) with is_point set, or the unit cross product of
//   rows 0 and 1 when row 2 of A is zero; singular flags a matrix with no answer
// output stream (m_*): one beat per solve, held in an output register
// the solve runs on the single bit-serial add/sub unit, one multiplier bit,
//   quotient bit or root bit per cycle
// s_tready is low for the whole solve, and the next beat is taken in the cycle
//   after the result is handed to the output register
// reset clears the matrix to zero and drops any held result
// when the receiver stalls the finished beat waits in the output register; the next
//   item is still taken, and its result waits until the register is free
`default_nettype none
module camera_point_unproject import cpu_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // entry_index, entry_value, coord_u, coord_v, coord_w (low to high), zero padded
  input  logic [((4+4*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  // command
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // point_x, point_y, point_z (low to high), zero padded
  output logic [((3*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
  // is_point, singular, saturated (low to high)
  output logic [2:0] m_tuser
);

  localparam int VW = VALUE_WIDTH;

  rflag_t rf;
  logic out_free;
  logic [VW-1:0] res_x, res_y, res_z;
  logic [VW-1:0] px, py, pz;
  logic [2:0] flags;

  // output register frees up in the same cycle it is taken
  assign out_free = !m_tvalid || m_tready;

  cpu_core #(.VW(VW), .FB(FRAC_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_index (s_tdata[3:0]),
    .in_value (s_tdata[4 +: VW]),
    .in_u     (s_tdata[4+VW +: VW]),
    .in_v     (s_tdata[4+2*VW +: VW]),
    .in_w     (s_tdata[4+3*VW +: VW]),
    .out_free (out_free),
    .rf       (rf),
    .res_x    (res_x),
    .res_y    (res_y),
    .res_z    (res_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rf.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (rf.valid) begin
      px    <= res_x;
      py    <= res_y;
      pz    <= res_z;
      flags <= {rf.saturated, rf.singular, rf.is_point};
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[3*VW-1:0] = {pz, py, px};
  end

  assign m_tuser = flags;

endmodule
`default_nettype wire
